### rtl/adsr_env_pkg.sv
// Package for the exponential ADSR envelope generator.
// Holds the fixed-point widths, level constants, stage, operation and register codes.
// No dependencies.
package adsr_env_pkg;

  localparam int FRAC_BITS = 23;                      // level fraction bits (Q1.23)
  localparam int LEVEL_W   = 24;                      // level field width
  localparam int COEFF_W   = 24;                      // coefficient width (Q0.24)
  localparam int TARGET_W  = LEVEL_W + 1;             // ONE + overshoot needs one extra bit
  localparam int PROD_W    = TARGET_W + COEFF_W;      // shared multiplier result width
  localparam int CFG_IDX_W = 3;                       // register index width

  localparam logic [LEVEL_W-1:0] ONE = LEVEL_W'(1) << FRAC_BITS;

  // fixed-point image of 1e-4, rounded up so "level < FLOOR" matches the real compare
  localparam int FLOOR_INT = ((1 << FRAC_BITS) + 9999) / 10000;
  localparam logic [LEVEL_W-1:0] FLOOR = LEVEL_W'(FLOOR_INT);

  // register reset values
  localparam logic [COEFF_W-1:0] ATTACK_COEFF_RST  = COEFF_W'(16000000);
  localparam logic [COEFF_W-1:0] DECAY_COEFF_RST   = COEFF_W'(16000000);
  localparam logic [COEFF_W-1:0] RELEASE_COEFF_RST = COEFF_W'(16000000);
  localparam logic [LEVEL_W-1:0] SUSTAIN_RST       = LEVEL_W'(8388608);
  localparam logic [LEVEL_W-1:0] OVERSHOOT_RST     = LEVEL_W'(2097152);

  typedef enum logic [2:0] {
    ST_IDLE    = 3'd0,
    ST_ATTACK  = 3'd1,
    ST_DECAY   = 3'd2,
    ST_SUSTAIN = 3'd3,
    ST_RELEASE = 3'd4
  } stage_t;

  typedef enum logic [1:0] {
    OP_TICK          = 2'd0,
    OP_NOTE_ON       = 2'd1,
    OP_NOTE_ON_LEVEL = 2'd2,
    OP_NOTE_OFF      = 2'd3
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ATTACK_COEFF     = 3'd0,
    REG_DECAY_COEFF      = 3'd1,
    REG_RELEASE_COEFF    = 3'd2,
    REG_SUSTAIN_LEVEL    = 3'd3,
    REG_ATTACK_OVERSHOOT = 3'd4
  } cfg_reg_t;

endpackage

### rtl/adsr_exponential_envelope.sv
// Exponential ADSR envelope generator, top level.
// Latency: the result of an item is valid the cycle after the item is accepted.
// Throughput: one item per cycle while no result is held back by result_stall; the level
//   feedback loop (one shared 25x24 multiply plus subtract and compare) is combinational.
// Reset (rst, synchronous, active high): stage idle, level zero, no result pending,
//   configuration registers back to their default values.
// Depends on adsr_env_pkg.
module adsr_exponential_envelope (
  input  logic                                clk,
  input  logic                                rst,
  // configuration write port
  input  logic                                cfg_write,
  input  logic [adsr_env_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [adsr_env_pkg::COEFF_W-1:0]    cfg_data,
  // input items
  input  logic                                item_valid,
  output logic                                item_stall,
  input  logic [1:0]                          operation,
  input  logic [adsr_env_pkg::LEVEL_W-1:0]    start_level,
  // result items
  output logic                                result_valid,
  input  logic                                result_stall,
  output logic [adsr_env_pkg::LEVEL_W-1:0]    envelope_level,
  output logic [2:0]                          stage
);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [adsr_env_pkg::COEFF_W-1:0] attack_coeff;
  logic [adsr_env_pkg::COEFF_W-1:0] decay_coeff;
  logic [adsr_env_pkg::COEFF_W-1:0] release_coeff;
  logic [adsr_env_pkg::LEVEL_W-1:0] sustain_level;
  logic [adsr_env_pkg::LEVEL_W-1:0] attack_overshoot;

  always_ff @(posedge clk) begin
    if (rst) begin
      attack_coeff     <= adsr_env_pkg::ATTACK_COEFF_RST;
      decay_coeff      <= adsr_env_pkg::DECAY_COEFF_RST;
      release_coeff    <= adsr_env_pkg::RELEASE_COEFF_RST;
      sustain_level    <= adsr_env_pkg::SUSTAIN_RST;
      attack_overshoot <= adsr_env_pkg::OVERSHOOT_RST;
    end else if (cfg_write) begin
      unique case (adsr_env_pkg::cfg_reg_t'(cfg_index))
        adsr_env_pkg::REG_ATTACK_COEFF:     attack_coeff     <= cfg_data;
        adsr_env_pkg::REG_DECAY_COEFF:      decay_coeff      <= cfg_data;
        adsr_env_pkg::REG_RELEASE_COEFF:    release_coeff    <= cfg_data;
        adsr_env_pkg::REG_SUSTAIN_LEVEL:    sustain_level    <= cfg_data;
        adsr_env_pkg::REG_ATTACK_OVERSHOOT: attack_overshoot <= cfg_data;
        default: ;  // indexes past the list are dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake. The envelope state registers double as the result register:
  // an item is taken whenever the held result is gone or leaving this cycle.
  // ---------------------------------------------------------------------------
  logic accept;

  assign item_stall = result_valid && result_stall;
  assign accept     = item_valid && !item_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (accept) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Envelope state
  // ---------------------------------------------------------------------------
  adsr_env_pkg::stage_t             current_stage;
  adsr_env_pkg::stage_t             current_stage_next;
  logic [adsr_env_pkg::LEVEL_W-1:0] current_level;
  logic [adsr_env_pkg::LEVEL_W-1:0] current_level_next;

  adsr_env_pkg::op_t op;
  assign op = adsr_env_pkg::op_t'(operation);

  // Saturated sustain level and start level
  logic [adsr_env_pkg::LEVEL_W-1:0] sus_sat;
  logic [adsr_env_pkg::LEVEL_W-1:0] start_sat;

  assign sus_sat   = (sustain_level > adsr_env_pkg::ONE) ? adsr_env_pkg::ONE : sustain_level;
  assign start_sat = (start_level > adsr_env_pkg::ONE) ? adsr_env_pkg::ONE : start_level;

  // Attack target and distance to it. Level never exceeds ONE, so diff >= 0.
  logic [adsr_env_pkg::TARGET_W-1:0] target;
  logic [adsr_env_pkg::TARGET_W-1:0] diff;

  assign target = adsr_env_pkg::TARGET_W'(adsr_env_pkg::ONE)
                + adsr_env_pkg::TARGET_W'(attack_overshoot);
  assign diff   = target - adsr_env_pkg::TARGET_W'(current_level);

  // One multiplier shared by attack, decay and release; operands picked by stage.
  logic [adsr_env_pkg::TARGET_W-1:0] mul_a;
  logic [adsr_env_pkg::COEFF_W-1:0]  mul_c;
  logic [adsr_env_pkg::PROD_W-1:0]   prod;
  logic [adsr_env_pkg::TARGET_W-1:0] scaled;

  always_comb begin
    mul_a = adsr_env_pkg::TARGET_W'(current_level);
    mul_c = decay_coeff;
    case (current_stage)
      adsr_env_pkg::ST_ATTACK: begin
        mul_a = diff;
        mul_c = attack_coeff;
      end
      adsr_env_pkg::ST_RELEASE: begin
        mul_c = release_coeff;
      end
      default: ;
    endcase
  end

  assign prod   = adsr_env_pkg::PROD_W'(mul_a) * adsr_env_pkg::PROD_W'(mul_c);
  assign scaled = prod[adsr_env_pkg::PROD_W-1:adsr_env_pkg::COEFF_W];  // truncate

  // Per-stage candidate levels and end-of-stage checks
  logic [adsr_env_pkg::TARGET_W-1:0] attack_level;
  logic [adsr_env_pkg::LEVEL_W-1:0]  decayed_level;
  logic                              attack_done;
  logic                              decay_done;
  logic                              release_done;

  assign attack_level  = target - scaled;
  assign decayed_level = scaled[adsr_env_pkg::LEVEL_W-1:0];  // (level*coeff) >> 24 < 2^24
  assign attack_done   = attack_level >= adsr_env_pkg::TARGET_W'(adsr_env_pkg::ONE);
  assign decay_done    = (decayed_level <= sus_sat) || (decayed_level < adsr_env_pkg::FLOOR);
  assign release_done  = decayed_level < adsr_env_pkg::FLOOR;

  // Next stage
  always_comb begin
    current_stage_next = current_stage;
    case (op)
      adsr_env_pkg::OP_TICK: begin
        unique case (current_stage)
          adsr_env_pkg::ST_ATTACK:
            if (attack_done) current_stage_next = adsr_env_pkg::ST_DECAY;
          adsr_env_pkg::ST_DECAY:
            if (decay_done) current_stage_next = adsr_env_pkg::ST_SUSTAIN;
          adsr_env_pkg::ST_SUSTAIN:
            current_stage_next = adsr_env_pkg::ST_SUSTAIN;
          adsr_env_pkg::ST_RELEASE:
            if (release_done) current_stage_next = adsr_env_pkg::ST_IDLE;
          default:
            current_stage_next = adsr_env_pkg::ST_IDLE;
        endcase
      end
      adsr_env_pkg::OP_NOTE_ON,
      adsr_env_pkg::OP_NOTE_ON_LEVEL: begin
        current_stage_next = adsr_env_pkg::ST_ATTACK;
      end
      default: begin  // note off; ignored while idle
        if (current_stage != adsr_env_pkg::ST_IDLE) current_stage_next = adsr_env_pkg::ST_RELEASE;
      end
    endcase
  end

  // Next level
  always_comb begin
    current_level_next = current_level;
    case (op)
      adsr_env_pkg::OP_TICK: begin
        case (current_stage)
          adsr_env_pkg::ST_ATTACK:
            current_level_next = attack_done ? adsr_env_pkg::ONE
                                             : attack_level[adsr_env_pkg::LEVEL_W-1:0];
          adsr_env_pkg::ST_DECAY:
            current_level_next = decay_done ? sus_sat : decayed_level;
          adsr_env_pkg::ST_SUSTAIN:
            current_level_next = sus_sat;
          adsr_env_pkg::ST_RELEASE:
            current_level_next = release_done ? '0 : decayed_level;
          default: ;
        endcase
      end
      adsr_env_pkg::OP_NOTE_ON:       current_level_next = '0;
      adsr_env_pkg::OP_NOTE_ON_LEVEL: current_level_next = start_sat;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_stage <= adsr_env_pkg::ST_IDLE;
      current_level <= '0;
    end else if (accept) begin
      current_stage <= current_stage_next;
      current_level <= current_level_next;
    end
  end

  assign envelope_level = current_level;
  assign stage          = current_stage;

endmodule

### rtl/adsr_env_checker.sv
// Port-level checker for the exponential ADSR envelope generator, plus its bind.
// Depends on adsr_env_pkg and the adsr_exponential_envelope top level.
module adsr_env_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                item_valid,
  input logic                                item_stall,
  input logic                                result_valid,
  input logic                                result_stall,
  input logic [adsr_env_pkg::LEVEL_W-1:0]    envelope_level,
  input logic [2:0]                          stage
);

  // a stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(envelope_level) && $stable(stage))
    else $error("stalled result changed");

  // every accepted item yields a result next cycle
  assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall |=> result_valid)
    else $error("accepted item produced no result");

  // input side stalls only while a result is held back
  assert property (@(posedge clk) disable iff (rst)
    item_stall == (result_valid && result_stall))
    else $error("item stall without held result");

  // level never above 1.0
  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> envelope_level <= adsr_env_pkg::ONE)
    else $error("envelope level above 1.0");

  // idle means silent
  assert property (@(posedge clk) disable iff (rst)
    result_valid && stage == adsr_env_pkg::ST_IDLE |-> envelope_level == '0)
    else $error("idle stage with nonzero level");

endmodule

bind adsr_exponential_envelope adsr_env_checker u_adsr_env_checker (.*);

### verif/adsr_exponential_envelope_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the exponential ADSR envelope generator.
// Drives items with random bursts and result stalls, checks every result against
// its own envelope predictor. Depends on adsr_env_pkg and adsr_exponential_envelope.
module adsr_exponential_envelope_test;

  localparam int CYCLE_LIMIT = 400_000;
  localparam int HOLD_CYCLES = 80;          // long receiver hold-off in the pressure test
  localparam int PHASE_ITEMS = 190;         // random items per configuration phase
  localparam int RANDOM_PHASES = 6;
  localparam int MAX_REPORTS = 10;
  // index past the register list; the block must ignore writes to it
  localparam logic [adsr_env_pkg::CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;

  // one result item
  typedef struct packed {
    logic [adsr_env_pkg::LEVEL_W-1:0] level;
    adsr_env_pkg::stage_t             stage;
  } envelope_out_t;

  logic                                 clk = 1'b0;
  logic                                 rst = 1'b1;
  logic                                 cfg_write = 1'b0;
  logic [adsr_env_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
  logic [adsr_env_pkg::COEFF_W-1:0]     cfg_data = '0;
  logic                                 item_valid = 1'b0;
  logic                                 item_stall;
  logic [1:0]                           operation = adsr_env_pkg::OP_TICK;
  logic [adsr_env_pkg::LEVEL_W-1:0]     start_level = '0;
  logic                                 result_valid;
  logic                                 result_stall = 1'b0;
  logic [adsr_env_pkg::LEVEL_W-1:0]     envelope_level;
  logic [2:0]                           stage;

  adsr_exponential_envelope dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .item_valid     (item_valid),
    .item_stall     (item_stall),
    .operation      (operation),
    .start_level    (start_level),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .envelope_level (envelope_level),
    .stage          (stage)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Envelope predictor: its own copy of the registers and the stage machine.
  // ---------------------------------------------------------------------------
  logic [adsr_env_pkg::COEFF_W-1:0] attack_coeff_reg  = adsr_env_pkg::ATTACK_COEFF_RST;
  logic [adsr_env_pkg::COEFF_W-1:0] decay_coeff_reg   = adsr_env_pkg::DECAY_COEFF_RST;
  logic [adsr_env_pkg::COEFF_W-1:0] release_coeff_reg = adsr_env_pkg::RELEASE_COEFF_RST;
  logic [adsr_env_pkg::LEVEL_W-1:0] sustain_reg       = adsr_env_pkg::SUSTAIN_RST;
  logic [adsr_env_pkg::LEVEL_W-1:0] overshoot_reg     = adsr_env_pkg::OVERSHOOT_RST;
  adsr_env_pkg::stage_t             env_stage         = adsr_env_pkg::ST_IDLE;
  logic [adsr_env_pkg::LEVEL_W-1:0] env_level         = '0;

  envelope_out_t expected_envelope[$];

  function automatic envelope_out_t advance_envelope(
      input adsr_env_pkg::op_t op,
      input logic [adsr_env_pkg::LEVEL_W-1:0] lvl);
    logic [63:0]   target;
    logic [63:0]   nxt;
    logic [63:0]   sus;
    envelope_out_t res;
    // sustain register saturates at 1.0 wherever it is used
    sus = (sustain_reg > adsr_env_pkg::ONE) ? 64'(adsr_env_pkg::ONE) : 64'(sustain_reg);
    case (op)
      adsr_env_pkg::OP_TICK: begin
        case (env_stage)
          adsr_env_pkg::ST_ATTACK: begin
            // pull toward 1.0 + overshoot; truncated product
            target = 64'(adsr_env_pkg::ONE) + 64'(overshoot_reg);
            nxt = target - (((target - 64'(env_level)) * 64'(attack_coeff_reg))
                            >> adsr_env_pkg::COEFF_W);
            if (nxt >= 64'(adsr_env_pkg::ONE)) begin
              env_level = adsr_env_pkg::ONE;
              env_stage = adsr_env_pkg::ST_DECAY;
            end else begin
              env_level = nxt[adsr_env_pkg::LEVEL_W-1:0];
            end
          end
          adsr_env_pkg::ST_DECAY: begin
            nxt = (64'(env_level) * 64'(decay_coeff_reg)) >> adsr_env_pkg::COEFF_W;
            // ends at sustain, or when it drops under the floor first
            if (nxt <= sus || nxt < 64'(adsr_env_pkg::FLOOR)) begin
              env_level = sus[adsr_env_pkg::LEVEL_W-1:0];
              env_stage = adsr_env_pkg::ST_SUSTAIN;
            end else begin
              env_level = nxt[adsr_env_pkg::LEVEL_W-1:0];
            end
          end
          adsr_env_pkg::ST_SUSTAIN: env_level = sus[adsr_env_pkg::LEVEL_W-1:0];
          adsr_env_pkg::ST_RELEASE: begin
            nxt = (64'(env_level) * 64'(release_coeff_reg)) >> adsr_env_pkg::COEFF_W;
            if (nxt < 64'(adsr_env_pkg::FLOOR)) begin
              env_level = '0;
              env_stage = adsr_env_pkg::ST_IDLE;
            end else begin
              env_level = nxt[adsr_env_pkg::LEVEL_W-1:0];
            end
          end
          default: env_stage = adsr_env_pkg::ST_IDLE;   // idle tick leaves everything alone
        endcase
      end
      adsr_env_pkg::OP_NOTE_ON: begin
        env_level = '0;
        env_stage = adsr_env_pkg::ST_ATTACK;
      end
      adsr_env_pkg::OP_NOTE_ON_LEVEL: begin
        env_level = (lvl > adsr_env_pkg::ONE) ? adsr_env_pkg::ONE : lvl;
        env_stage = adsr_env_pkg::ST_ATTACK;
      end
      default: begin
        // note off is ignored while idle
        if (env_stage != adsr_env_pkg::ST_IDLE) env_stage = adsr_env_pkg::ST_RELEASE;
      end
    endcase
    res.level = env_level;
    res.stage = env_stage;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Item sender: bursts of random length with random gaps in between.
  // ---------------------------------------------------------------------------
  int burst_left = 0;
  int items_sent = 0;

  task automatic send_item(input adsr_env_pkg::op_t op,
                           input logic [adsr_env_pkg::LEVEL_W-1:0] lvl);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 6);
      @(negedge clk);
      item_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
      // mix of short bursts and long stretches without gaps
      burst_left = ($urandom_range(3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
    end
    @(negedge clk);
    item_valid  <= 1'b1;
    operation   <= op;
    start_level <= lvl;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    expected_envelope.push_back(advance_envelope(op, lvl));
    burst_left--;
    items_sent++;
  endtask

  // Register write; only once the block has drained every pending result.
  task automatic write_register(input logic [adsr_env_pkg::CFG_IDX_W-1:0] index,
                                input logic [adsr_env_pkg::COEFF_W-1:0] data);
    @(negedge clk);
    item_valid <= 1'b0;
    while (expected_envelope.size() != 0) @(posedge clk);
    repeat (2) @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    @(negedge clk);
    cfg_write <= 1'b0;
    case (index)
      adsr_env_pkg::REG_ATTACK_COEFF:     attack_coeff_reg  = data;
      adsr_env_pkg::REG_DECAY_COEFF:      decay_coeff_reg   = data;
      adsr_env_pkg::REG_RELEASE_COEFF:    release_coeff_reg = data;
      adsr_env_pkg::REG_SUSTAIN_LEVEL:    sustain_reg       = data;
      adsr_env_pkg::REG_ATTACK_OVERSHOOT: overshoot_reg     = data;
      default: ;                              // unmapped index: no effect
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: stall pattern in segments of varying density, plus a long
  // hold-off on request from the pressure test.
  // ---------------------------------------------------------------------------
  bit hold_request = 1'b0;
  int hold_left = 0;
  int segment_left = 0;
  int stall_pct = 0;

  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      result_stall <= 1'b1;
    end else if (hold_request) begin
      hold_request = 1'b0;
      hold_left = HOLD_CYCLES - 1;
      result_stall <= 1'b1;
    end else begin
      if (segment_left == 0) begin
        segment_left = $urandom_range(10, 60);
        case ($urandom_range(4))
          0, 1:    stall_pct = 0;               // no stalls at all
          2:       stall_pct = 20;
          3:       stall_pct = 50;
          default: stall_pct = 85;
        endcase
      end
      segment_left = segment_left - 1;
      result_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker: each accepted result against the oldest expectation.
  // ---------------------------------------------------------------------------
  int mismatch_count = 0;

  always @(posedge clk) begin
    envelope_out_t want;
    if (!rst && result_valid && !result_stall) begin
      if (expected_envelope.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("%0t: unexpected result level=%0d stage=%0d",
                   $realtime, envelope_level, stage);
      end else begin
        want = expected_envelope.pop_front();
        if (envelope_level !== want.level || stage !== want.stage) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("%0t: mismatch expected level=%0d stage=%0d, got level=%0d stage=%0d",
                     $realtime, want.level, want.stage, envelope_level, stage);
        end
      end
    end
  end

  // watchdog
  int cycle_count = 0;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset registers: idle tick, idle note off, saturated start level, attack
  // clamp, decay straight to sustain, release, note on restarting from release.
  task automatic test_note_events();
    send_item(adsr_env_pkg::OP_TICK, 24'hFFFFFF);
    send_item(adsr_env_pkg::OP_NOTE_OFF, 24'hFFFFFF);
    send_item(adsr_env_pkg::OP_NOTE_ON_LEVEL, 24'hFFFFFF);
    send_item(adsr_env_pkg::OP_TICK, '0);
    send_item(adsr_env_pkg::OP_TICK, '0);
    send_item(adsr_env_pkg::OP_TICK, '0);
    send_item(adsr_env_pkg::OP_NOTE_OFF, '0);
    send_item(adsr_env_pkg::OP_NOTE_ON, 24'hFFFFFF);
    send_item(adsr_env_pkg::OP_NOTE_ON_LEVEL, adsr_env_pkg::ONE);
    send_item(adsr_env_pkg::OP_TICK, '0);
  endtask

  // All-zero and all-ones registers, then the floor ends of decay and release.
  task automatic test_register_extremes();
    write_register(adsr_env_pkg::REG_ATTACK_COEFF, '0);
    write_register(adsr_env_pkg::REG_DECAY_COEFF, '0);
    write_register(adsr_env_pkg::REG_RELEASE_COEFF, '0);
    write_register(adsr_env_pkg::REG_SUSTAIN_LEVEL, '0);
    write_register(adsr_env_pkg::REG_ATTACK_OVERSHOOT, '0);
    write_register(REG_UNMAPPED, '1);
    send_item(adsr_env_pkg::OP_NOTE_ON, '0);
    send_item(adsr_env_pkg::OP_TICK, '0);     // attack ends at 1.0 at once
    send_item(adsr_env_pkg::OP_TICK, '0);     // decay ends at zero sustain
    send_item(adsr_env_pkg::OP_NOTE_OFF, '0);
    send_item(adsr_env_pkg::OP_TICK, '0);     // release ends, idle

    write_register(adsr_env_pkg::REG_ATTACK_COEFF, '1);
    write_register(adsr_env_pkg::REG_DECAY_COEFF, '1);
    write_register(adsr_env_pkg::REG_RELEASE_COEFF, '1);
    write_register(adsr_env_pkg::REG_SUSTAIN_LEVEL, '1);    // above 1.0, saturates
    write_register(adsr_env_pkg::REG_ATTACK_OVERSHOOT, '1);
    send_item(adsr_env_pkg::OP_NOTE_ON_LEVEL, adsr_env_pkg::ONE - 1);
    send_item(adsr_env_pkg::OP_TICK, '0);
    send_item(adsr_env_pkg::OP_TICK, '0);
    send_item(adsr_env_pkg::OP_NOTE_OFF, '0);
    send_item(adsr_env_pkg::OP_TICK, '0);

    // tiny decay/release multipliers: decay and release end by falling under the floor
    write_register(adsr_env_pkg::REG_ATTACK_COEFF, '0);
    write_register(adsr_env_pkg::REG_DECAY_COEFF, adsr_env_pkg::COEFF_W'(16777));
    write_register(adsr_env_pkg::REG_RELEASE_COEFF, adsr_env_pkg::COEFF_W'(16777));
    write_register(adsr_env_pkg::REG_SUSTAIN_LEVEL, '0);
    send_item(adsr_env_pkg::OP_NOTE_ON_LEVEL, adsr_env_pkg::ONE);
    send_item(adsr_env_pkg::OP_TICK, '0);
    send_item(adsr_env_pkg::OP_TICK, '0);
    send_item(adsr_env_pkg::OP_TICK, '0);     // below floor, above sustain: ends decay
    send_item(adsr_env_pkg::OP_NOTE_ON, '0);
    send_item(adsr_env_pkg::OP_TICK, '0);
    send_item(adsr_env_pkg::OP_TICK, '0);
    send_item(adsr_env_pkg::OP_NOTE_OFF, '0);
    send_item(adsr_env_pkg::OP_TICK, '0);
  endtask

  // Receiver holds off for a long stretch while a gapless burst keeps coming.
  task automatic test_backpressure();
    write_register(adsr_env_pkg::REG_ATTACK_COEFF, adsr_env_pkg::ATTACK_COEFF_RST);
    write_register(adsr_env_pkg::REG_DECAY_COEFF, adsr_env_pkg::DECAY_COEFF_RST);
    write_register(adsr_env_pkg::REG_RELEASE_COEFF, adsr_env_pkg::RELEASE_COEFF_RST);
    write_register(adsr_env_pkg::REG_SUSTAIN_LEVEL, adsr_env_pkg::LEVEL_W'(4194304));
    write_register(adsr_env_pkg::REG_ATTACK_OVERSHOOT, adsr_env_pkg::OVERSHOOT_RST);
    hold_request = 1'b1;
    burst_left = 48;
    send_item(adsr_env_pkg::OP_NOTE_ON_LEVEL,
              adsr_env_pkg::LEVEL_W'($urandom_range(adsr_env_pkg::ONE)));
    repeat (30) send_item(adsr_env_pkg::OP_TICK, adsr_env_pkg::LEVEL_W'($urandom()));
    send_item(adsr_env_pkg::OP_NOTE_OFF, adsr_env_pkg::LEVEL_W'($urandom()));
    repeat (16) send_item(adsr_env_pkg::OP_TICK, adsr_env_pkg::LEVEL_W'($urandom()));
  endtask

  function automatic logic [adsr_env_pkg::COEFF_W-1:0] pick_coeff();
    case ($urandom_range(15))
      0, 1:    return '0;
      2:       return '1;
      default: return adsr_env_pkg::COEFF_W'($urandom_range(16_300_000, 11_000_000));
    endcase
  endfunction

  // Mostly whole notes with random content under random registers; some noise.
  task automatic test_random_notes();
    int phase_start;
    int n;
    logic [adsr_env_pkg::LEVEL_W-1:0] lvl;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      write_register(adsr_env_pkg::REG_ATTACK_COEFF, pick_coeff());
      write_register(adsr_env_pkg::REG_DECAY_COEFF, pick_coeff());
      write_register(adsr_env_pkg::REG_RELEASE_COEFF, pick_coeff());
      write_register(adsr_env_pkg::REG_SUSTAIN_LEVEL, ($urandom_range(3) == 0) ?
                     adsr_env_pkg::COEFF_W'($urandom()) :
                     adsr_env_pkg::COEFF_W'($urandom_range(adsr_env_pkg::ONE)));
      write_register(adsr_env_pkg::REG_ATTACK_OVERSHOOT, ($urandom_range(7) == 0) ?
                     '1 : adsr_env_pkg::COEFF_W'($urandom_range(adsr_env_pkg::ONE)));
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS) begin
        lvl = ($urandom_range(1) == 0) ? adsr_env_pkg::LEVEL_W'($urandom()) :
              adsr_env_pkg::LEVEL_W'($urandom_range(adsr_env_pkg::ONE));
        if ($urandom_range(99) < 12) begin
          // noise: any operation, any start level
          send_item(adsr_env_pkg::op_t'($urandom_range(3)), lvl);
        end else begin
          send_item(($urandom_range(1) == 0) ? adsr_env_pkg::OP_NOTE_ON :
                    adsr_env_pkg::OP_NOTE_ON_LEVEL, lvl);
          n = $urandom_range(70);
          repeat (n) send_item(adsr_env_pkg::OP_TICK, adsr_env_pkg::LEVEL_W'($urandom()));
          if ($urandom_range(9) != 0)
            send_item(adsr_env_pkg::OP_NOTE_OFF, adsr_env_pkg::LEVEL_W'($urandom()));
          n = $urandom_range(120);
          repeat (n) send_item(adsr_env_pkg::OP_TICK, adsr_env_pkg::LEVEL_W'($urandom()));
        end
      end
    end
  endtask

  initial begin
    // synchronous reset, released on a falling clock edge
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_note_events();
    test_register_extremes();
    test_backpressure();
    test_random_notes();

    // drain, then keep clocking to catch stray results
    @(negedge clk);
    item_valid <= 1'b0;
    while (expected_envelope.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
